FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define CSQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csq assertion failed");

// Checked on every rising clock edge, reset included.
`define CSQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("csq assertion failed");

`endif

FILE: rtl/csq_pkg.sv
// Types and constants of the coalescing signal queue.
// No dependencies.
`default_nettype none

package csq_pkg;

  localparam int NumContexts = 16;
  localparam int CtxW        = 4;
  localparam int CntW        = 32;

  typedef enum logic [1:0] {
    CmdSubmit  = 2'd0,
    CmdWait    = 2'd1,
    CmdRelease = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]      command;
    logic [CtxW-1:0] context_id;
    logic [CntW-1:0] add_count;
  } csq_in_t;

  typedef struct packed {
    logic [CtxW-1:0] delivered_context;
    logic [CntW-1:0] delivered_count;
  } csq_out_t;

  // broadcast to the context cells
  typedef struct packed {
    logic [CtxW-1:0] target;
    logic            write_count;
    logic [CntW-1:0] count_value;
    logic            set_queued;
    logic            clr_queued;
  } ctx_op_t;

  // broadcast to the queue slot cells
  typedef struct packed {
    logic [CtxW-1:0] id;
    logic            pop;
    logic            append;
    logic            remove;
  } slot_op_t;

endpackage

`default_nettype wire

FILE: rtl/csq_ctx_cell.sv
// One context: pending count and queued flag, updated from the broadcast op.
// Depends on csq_pkg.
`default_nettype none

module csq_ctx_cell import csq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CtxW-1:0] cell_id_i,
  input  ctx_op_t         op_i,
  output logic [CntW-1:0] count_o,
  output logic            queued_o
);

  logic [CntW-1:0] count_q, count_d;
  logic            queued_q, queued_d;
  logic            sel;

  assign sel = (op_i.target == cell_id_i);

  always_comb begin
    count_d  = count_q;
    queued_d = queued_q;
    if (sel && op_i.write_count) begin
      count_d = op_i.count_value;
    end
    if (sel && op_i.set_queued) begin
      queued_d = 1'b1;
    end
    if (sel && op_i.clr_queued) begin
      queued_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      queued_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      queued_q <= queued_d;
    end
  end

  assign count_o  = sel ? count_q : '0;
  assign queued_o = sel & queued_q;

endmodule

`default_nettype wire

FILE: rtl/csq_slot_cell.sv
// One slot of the order queue; shifts toward the head on pop or removal.
// Depends on csq_pkg.
`default_nettype none

module csq_slot_cell import csq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  slot_op_t        op_i,
  input  logic            prev_valid_i,
  input  logic            next_valid_i,
  input  logic [CtxW-1:0] next_id_i,
  input  logic            hit_i,
  output logic            hit_o,
  output logic            valid_o,
  output logic [CtxW-1:0] id_o
);

  logic            valid_q, valid_d;
  logic [CtxW-1:0] id_q, id_d;
  logic            hit_here;
  logic            shift;

  // hit_o: the removed entry sits in this slot or one nearer the head
  assign hit_here = op_i.remove & valid_q & (id_q == op_i.id);
  assign hit_o    = hit_i | hit_here;
  assign shift    = op_i.pop | (op_i.remove & hit_o);

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    priority if (shift) begin
      valid_d = next_valid_i;
      id_d    = next_id_i;
    end else if (op_i.append && !valid_q && prev_valid_i) begin
      valid_d = 1'b1;
      id_d    = op_i.id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;

endmodule

`default_nettype wire

FILE: rtl/coalescing_signal_queue.sv
// Coalescing signal queue: context cells plus a chain of order queue slots.
// Depends on csq_pkg, csq_ctx_cell, csq_slot_cell.
//
//   channel   handshake                 payload
//   command   start & !busy             cmd_i    (csq_in_t)
//   result    result_valid_o, 1 cycle   result_o (csq_out_t)
//
// Each command is captured, then executed in a cycle in which the context
// cells and the slot chain update together; busy is high during execute.
// A result appears in the cycle after execute, for one cycle only.
// Reset clears all counts, flags, slot valid bits and the blocked waiter.
// The receiver cannot stall; a new command may be taken while a result shows.
`default_nettype none

module coalescing_signal_queue import csq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  csq_in_t  cmd_i,
  output logic     busy,
  output logic     result_valid_o,
  output csq_out_t result_o
);

  logic     busy_q;
  csq_in_t  cmd_q;
  logic     blocked_q, blocked_d;
  logic     res_valid_q, res_valid_d;
  csq_out_t res_q, res_d;

  ctx_op_t  ctx_op;
  slot_op_t slot_op;

  logic [CntW-1:0] cell_count [NumContexts];
  logic            cell_queued [NumContexts];
  logic            slot_valid [NumContexts];
  logic [CtxW-1:0] slot_id [NumContexts];
  logic            hit [NumContexts+1];

  logic [CntW-1:0] rd_count;
  logic            rd_queued;
  logic            ctx_ok;
  logic [CntW:0]   sum_wide;
  logic [CntW-1:0] sum_sat;

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < NumContexts; i++) begin : g_cells
    csq_ctx_cell u_ctx (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cell_id_i(CtxW'(i)),
      .op_i     (ctx_op),
      .count_o  (cell_count[i]),
      .queued_o (cell_queued[i])
    );

    csq_slot_cell u_slot (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (slot_op),
      .prev_valid_i((i == 0) ? 1'b1 : slot_valid[(i == 0) ? 0 : i-1]),
      .next_valid_i((i == NumContexts-1) ? 1'b0 :
                    slot_valid[(i == NumContexts-1) ? i : i+1]),
      .next_id_i   ((i == NumContexts-1) ? '0 :
                    slot_id[(i == NumContexts-1) ? i : i+1]),
      .hit_i       (hit[i]),
      .hit_o       (hit[i+1]),
      .valid_o     (slot_valid[i]),
      .id_o        (slot_id[i])
    );
  end

  // only the addressed cell drives a nonzero value
  always_comb begin
    rd_count  = '0;
    rd_queued = 1'b0;
    for (int i = 0; i < NumContexts; i++) begin
      rd_count  = rd_count | cell_count[i];
      rd_queued = rd_queued | cell_queued[i];
    end
  end

  assign ctx_ok   = (32'(cmd_q.context_id) < NumContexts);
  assign sum_wide = {1'b0, rd_count} + {1'b0, cmd_q.add_count};
  assign sum_sat  = sum_wide[CntW] ? '1 : sum_wide[CntW-1:0];

  always_comb begin
    ctx_op             = '0;
    ctx_op.target      = (cmd_e'(cmd_q.command) == CmdWait) ? slot_id[0]
                                                            : cmd_q.context_id;
    slot_op            = '0;
    slot_op.id         = cmd_q.context_id;
    blocked_d          = blocked_q;
    res_valid_d        = 1'b0;
    res_d              = res_q;
    if (busy_q) begin
      unique case (cmd_e'(cmd_q.command))
        CmdSubmit: begin
          if (ctx_ok) begin
            ctx_op.write_count = 1'b1;
            if (blocked_q) begin
              ctx_op.count_value      = '0;
              blocked_d               = 1'b0;
              res_valid_d             = 1'b1;
              res_d.delivered_context = cmd_q.context_id;
              res_d.delivered_count   = sum_sat;
            end else begin
              ctx_op.count_value = sum_sat;
              if (!rd_queued) begin
                ctx_op.set_queued = 1'b1;
                slot_op.append    = 1'b1;
              end
            end
          end
        end
        CmdWait: begin
          if (!slot_valid[0]) begin
            blocked_d = 1'b1;
          end else begin
            ctx_op.write_count      = 1'b1;
            ctx_op.count_value      = '0;
            ctx_op.clr_queued       = 1'b1;
            slot_op.pop             = 1'b1;
            res_valid_d             = 1'b1;
            res_d.delivered_context = slot_id[0];
            res_d.delivered_count   = rd_count;
          end
        end
        CmdRelease: begin
          if (ctx_ok && rd_queued) begin
            ctx_op.clr_queued = 1'b1;
            slot_op.remove    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      blocked_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= start & ~busy_q;
      blocked_q   <= blocked_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy_q) begin
      cmd_q <= cmd_i;
    end
    res_q <= res_d;
  end

  assign busy           = busy_q;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

FILE: rtl/csq_checker.sv
// Port-level checks of the coalescing signal queue, bound to the top level.
// Depends on assert_macros.svh and coalescing_signal_queue.
`default_nettype none
`include "assert_macros.svh"

module csq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o
);

  `CSQ_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `CSQ_ASSERT(a_exec_one_cycle, clk_i, rst_ni, busy |=> !busy)
  `CSQ_ASSERT(a_result_after_exec, clk_i, rst_ni, result_valid_o |-> (!busy && $past(busy)))
  `CSQ_ASSERT(a_result_single, clk_i, rst_ni, result_valid_o |=> !result_valid_o)
  `CSQ_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> (!busy && !result_valid_o))

endmodule

bind coalescing_signal_queue csq_checker u_csq_checker (.*);

`default_nettype wire

FILE: bench/coalescing_signal_queue_test.sv
// Self-checking bench for coalescing_signal_queue: directed and random command
// streams, a scoreboard that predicts each delivery, random idle gaps.
// Depends on csq_pkg and the coalescing_signal_queue RTL.
`default_nettype none

module coalescing_signal_queue_test;
  import csq_pkg::*;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int StallLimit = 2000;
  localparam int RandomCommands = 1700;

  class signal_queue_scoreboard;
    logic [CntW-1:0] pending [NumContexts];
    bit              queued  [NumContexts];
    logic [CtxW-1:0] order[$];
    bit              waiter_blocked;
    csq_out_t        due_deliveries[$];
    int              errors;
    int              deliveries;
    int              saturations;

    function new();
      foreach (pending[i]) begin
        pending[i] = '0;
        queued[i]  = 1'b0;
      end
      waiter_blocked = 1'b0;
      errors = 0;
      deliveries = 0;
      saturations = 0;
    endfunction

    function void push_delivery(logic [CtxW-1:0] ctx);
      csq_out_t d;
      d.delivered_context = ctx;
      d.delivered_count   = pending[ctx];
      pending[ctx] = '0;
      due_deliveries.push_back(d);
    endfunction

    function void note_command(csq_in_t c);
      logic [CntW:0]   sum;
      logic [CtxW-1:0] head;
      case (c.command)
        CmdWait: begin
          if (order.size() == 0) begin
            waiter_blocked = 1'b1;
          end else begin
            head = order.pop_front();
            queued[head] = 1'b0;
            push_delivery(head);
          end
        end
        CmdSubmit: begin
          sum = {1'b0, pending[c.context_id]} + {1'b0, c.add_count};
          if (sum[CntW]) saturations++;
          pending[c.context_id] = sum[CntW] ? '1 : sum[CntW-1:0];
          if (waiter_blocked) begin
            waiter_blocked = 1'b0;
            push_delivery(c.context_id);
          end else if (!queued[c.context_id] && order.size() < NumContexts) begin
            order.push_back(c.context_id);
            queued[c.context_id] = 1'b1;
          end
        end
        CmdRelease: begin
          if (queued[c.context_id]) begin
            for (int i = order.size() - 1; i >= 0; i--)
              if (order[i] == c.context_id) order.delete(i);
            queued[c.context_id] = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(csq_out_t got);
      csq_out_t want;
      if (due_deliveries.size() == 0) begin
        $display("%0t: unexpected delivery ctx=%0d count=%h", $time,
                 got.delivered_context, got.delivered_count);
        errors++;
        return;
      end
      want = due_deliveries.pop_front();
      deliveries++;
      if (got.delivered_context !== want.delivered_context) begin
        $display("%0t: delivered_context mismatch: expected %0d actual %0d", $time,
                 want.delivered_context, got.delivered_context);
        errors++;
      end
      if (got.delivered_count !== want.delivered_count) begin
        $display("%0t: delivered_count mismatch: expected %h actual %h", $time,
                 want.delivered_count, got.delivered_count);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  csq_in_t  cmd_i;
  logic     busy;
  logic     result_valid_o;
  csq_out_t result_o;

  signal_queue_scoreboard sb = new();
  int issued;
  int stall_cycles;

  coalescing_signal_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .cmd_i         (cmd_i),
    .busy          (busy),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(result_o);
      if (start && !busy) begin
        sb.note_command(cmd_i);
        issued++;
      end
      if (result_valid_o || (start && !busy)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("%0t: no transaction for %0d cycles", $time, StallLimit);
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  task automatic issue(logic [1:0] cmd, logic [CtxW-1:0] ctx, logic [CntW-1:0] add);
    csq_in_t c;
    c.command    = cmd;
    c.context_id = ctx;
    c.add_count  = add;
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic idle(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.due_deliveries.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [CntW-1:0] random_add();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 255);
    if (r < 8) return $urandom;
    if (r == 8) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    return '0;
  endfunction

  initial begin
    int n;
    int pick;
    int submit_bias;
    bit idle_on;
    logic [CtxW-1:0] ctx;

    rst_ni = 1'b0;
    start  = 1'b0;
    cmd_i  = '0;
    issued = 0;
    stall_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    issue(CmdSubmit, 4'd0, 32'hFFFF_FFFF);
    issue(CmdSubmit, 4'd0, 32'd5);
    issue(CmdSubmit, 4'd15, 32'd0);
    issue(CmdSubmit, 4'd15, 32'd1);
    issue(CmdRelease, 4'd7, 32'd0);
    issue(CmdUnused, 4'd15, 32'hFFFF_FFFF);
    issue(CmdWait, 4'd0, 32'd0);
    issue(CmdWait, 4'd0, 32'd0);
    idle(2);
    issue(CmdWait, 4'd0, 32'd0);
    issue(CmdWait, 4'd0, 32'd0);
    issue(CmdSubmit, 4'd9, 32'hAAAA_AAAA);
    issue(CmdSubmit, 4'd3, 32'h5555_5555);
    issue(CmdSubmit, 4'd4, 32'd1);
    issue(CmdSubmit, 4'd5, 32'd2);
    issue(CmdRelease, 4'd4, 32'd0);
    issue(CmdWait, 4'd0, 32'd0);
    issue(CmdWait, 4'd0, 32'd0);
    issue(CmdSubmit, 4'd8, 32'd7);
    issue(CmdRelease, 4'd8, 32'd0);
    issue(CmdWait, 4'd0, 32'd0);
    issue(CmdSubmit, 4'd2, 32'd3);
    drain();

    n = 0;
    idle_on = 1'b0;
    submit_bias = 50;
    while (n < RandomCommands) begin
      if (n % 100 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
        submit_bias = $urandom_range(35, 65);
      end
      if (n % 400 == 399) drain();
      pick = $urandom_range(0, 99);
      ctx = CtxW'($urandom_range(0, NumContexts - 1));
      if (pick < 4) begin
        issue(CmdUnused, ctx, $urandom);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < submit_bias) begin
          issue(CmdSubmit, ctx, random_add());
        end else if (pick < submit_bias + (100 - submit_bias) * 2 / 3) begin
          issue(CmdWait, ctx, $urandom);
        end else begin
          if (sb.order.size() != 0 && $urandom_range(0, 4) != 0)
            ctx = sb.order[$urandom_range(0, sb.order.size() - 1)];
          issue(CmdRelease, ctx, $urandom);
        end
        n++;
      end
      if (idle_on) begin
        pick = gap_length();
        if (pick != 0) idle(pick);
      end
    end
    drain();
    repeat (10) @(posedge clk_i);

    $display("tb: %0d commands issued, %0d deliveries checked, %0d saturating submits",
             issued, sb.deliveries, sb.saturations);
    if (sb.errors == 0 && sb.due_deliveries.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
